@@ design/bgs_pkg.sv @@
// Shared types and constants for the bucketed galloping search block.
// No dependencies; imported by bgs_step_unit and bucketed_galloping_search.
package bgs_pkg;

  localparam int POS_W  = 32;
  localparam int BIDX_W = 4;
  localparam int RES_W  = 7;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STEP_GPROBE,
    STEP_GCMP,
    STEP_SETUP,
    STEP_BPROBE,
    STEP_BCMP
  } step_op_t;

  typedef struct packed {
    logic less;
    logic more;
    logic count_zero;
  } step_flags_t;

endpackage

@@ design/bgs_step_unit.sv @@
// Shared compare and index arithmetic for the gallop and binary search steps.
// Depends on bgs_pkg for the step codes and the flag struct.
module bgs_step_unit
  import bgs_pkg::*;
#(
  parameter int CW = 7,
  parameter int PW = 32
) (
  input  step_op_t      op,
  input  logic [PW-1:0] entry,
  input  logic [PW-1:0] query_end,
  input  logic [CW-1:0] cur,
  input  logic [CW-1:0] len,
  input  logic [CW:0]   bound,
  input  logic [CW-1:0] lo,
  input  logic [CW-1:0] count,
  input  logic [CW-1:0] mid,
  output logic [CW-1:0] sum,
  output logic [CW:0]   bound_next,
  output logic [CW-1:0] count_next,
  output step_flags_t   flags
);

  logic [CW-1:0] size;
  logic [CW-1:0] half_bound;
  logic [CW-1:0] half_count;
  logic [CW-1:0] up;
  logic [CW-1:0] add_a;
  logic [CW-1:0] add_b;
  logic [CW:0]   bound_dbl;

  always_comb begin
    size       = len - cur;
    half_bound = bound[CW:1];
    half_count = count >> 1;
    bound_dbl  = bound << 1;
    up         = (bound < {1'b0, size}) ? bound[CW-1:0] : size;

    flags.less       = entry < query_end;
    flags.more       = flags.less && (bound_dbl < {1'b0, size});
    flags.count_zero = count == '0;

    bound_next = bound;
    count_next = count;
    add_a      = cur;
    add_b      = bound[CW-1:0];
    case (op)
      STEP_GPROBE: begin
        add_a = cur;
        add_b = bound[CW-1:0];
      end
      STEP_GCMP: begin
        bound_next = flags.less ? bound_dbl : bound;
      end
      STEP_SETUP: begin
        add_a      = cur;
        add_b      = half_bound;
        count_next = up - half_bound;
      end
      STEP_BPROBE: begin
        add_a = lo;
        add_b = half_count;
      end
      STEP_BCMP: begin
        add_a      = mid;
        add_b      = CW'(1);
        count_next = flags.less ? (count - half_count - CW'(1)) : half_count;
      end
      default: begin
        add_a = cur;
      end
    endcase
    sum = add_a + add_b;
  end

endmodule

@@ design/bucketed_galloping_search.sv @@
// Top level: sequencer, entry memory and per-bucket fill/cursor memory.
// Depends on bgs_pkg and bgs_step_unit.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, operation,            | into block
//           | bucket_index, position                    |
//   out     | out_valid, out_ready, status,             | out of block
//           | found_index, bucket_length                |
//
// An append goes from DECIDE to FINISH, where its result is loaded. A search
// with its cursor below the fill count runs DECIDE, gallop probes (GREAD, GCMP)
// while the bound doubles, BSETUP, binary probes (BREAD, BCMP) until the count
// is zero, and FINISH; every probe is one read of the entry memory with its
// registered read data. A clearing pass after reset zeroes all NUM_BUCKETS
// fill counts and cursors; no item is accepted until it ends. A waiting result
// does not block the next item from being accepted, only from being delivered.
module bucketed_galloping_search
  import bgs_pkg::*;
#(
  parameter int NUM_BUCKETS  = 16,
  parameter int BUCKET_DEPTH = 64,
  parameter int POS_BITS     = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [BIDX_W-1:0] bucket_index,
  input  logic [POS_W-1:0]  position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [RES_W-1:0]  found_index,
  output logic [RES_W-1:0]  bucket_length
);

  localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IW   = $clog2(BUCKET_DEPTH);
  localparam int CW   = $clog2(BUCKET_DEPTH + 1);
  localparam int AW   = BW + IW;
  localparam int MW   = 2 * CW;
  localparam int NMAP = 2 ** BIDX_W;
  localparam logic [CW:0] BOUND_ONE = 1;

  typedef logic [BW-1:0] bmap_t [NMAP];

  function automatic bmap_t build_map();
    bmap_t m;
    for (int i = 0; i < NMAP; i++) begin
      m[i] = BW'(i % NUM_BUCKETS);
    end
    return m;
  endfunction

  localparam bmap_t BMAP = build_map();

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DECIDE = 9'b000000100,
    ST_GREAD  = 9'b000001000,
    ST_GCMP   = 9'b000010000,
    ST_BSETUP = 9'b000100000,
    ST_BREAD  = 9'b001000000,
    ST_BCMP   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t              state;
  logic [BW-1:0]       clr_idx;
  op_t                 op_r;
  logic [BW-1:0]       bkt;
  logic [POS_BITS-1:0] qend;
  logic [CW-1:0]       cur;
  logic [CW-1:0]       len;
  logic [CW-1:0]       lo;
  logic [CW-1:0]       count;
  logic [CW-1:0]       mid;
  logic [CW:0]         bound;
  logic                res_status;
  logic [CW-1:0]       res_len;

  logic [POS_BITS-1:0] entry_mem [2**AW];
  logic [POS_BITS-1:0] ent_rdata;
  logic [MW-1:0]       meta_mem [NUM_BUCKETS];
  logic [MW-1:0]       meta_rdata;

  logic                accept;
  logic                out_load;
  logic [CW-1:0]       meta_fill;
  logic [CW-1:0]       meta_cur;
  logic                room;
  logic                ent_we;
  logic [AW-1:0]       ent_waddr;
  logic [AW-1:0]       ent_raddr;
  logic                meta_we;
  logic [BW-1:0]       meta_waddr;
  logic [MW-1:0]       meta_wdata;
  logic [BW-1:0]       meta_raddr;

  step_op_t            step_op;
  logic [CW-1:0]       sum;
  logic [CW:0]         bound_nx;
  logic [CW-1:0]       count_nx;
  step_flags_t         flags;

  bgs_step_unit #(
    .CW(CW),
    .PW(POS_BITS)
  ) u_step (
    .op        (step_op),
    .entry     (ent_rdata),
    .query_end (qend),
    .cur       (cur),
    .len       (len),
    .bound     (bound),
    .lo        (lo),
    .count     (count),
    .mid       (mid),
    .sum       (sum),
    .bound_next(bound_nx),
    .count_next(count_nx),
    .flags     (flags)
  );

  always_comb begin
    case (state)
      ST_GREAD:  step_op = STEP_GPROBE;
      ST_GCMP:   step_op = STEP_GCMP;
      ST_BSETUP: step_op = STEP_SETUP;
      ST_BREAD:  step_op = STEP_BPROBE;
      ST_BCMP:   step_op = STEP_BCMP;
      default:   step_op = STEP_GPROBE;
    endcase
  end

  assign in_ready   = state == ST_IDLE;
  assign accept     = in_valid && in_ready;
  assign out_load   = (state == ST_FINISH) && (!out_valid || out_ready);
  assign meta_fill  = meta_rdata[MW-1:CW];
  assign meta_cur   = meta_rdata[CW-1:0];
  assign room       = meta_fill < CW'(BUCKET_DEPTH);
  assign ent_we     = (state == ST_DECIDE) && (op_r == OP_APPEND) && room;
  assign ent_waddr  = {bkt, meta_fill[IW-1:0]};
  assign ent_raddr  = {bkt, sum[IW-1:0]};
  assign meta_raddr = BMAP[bucket_index];

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = bkt;
    meta_wdata = {len, lo};
    if (state == ST_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_idx;
      meta_wdata = '0;
    end else if (ent_we) begin
      meta_we    = 1'b1;
      meta_wdata = {meta_fill + CW'(1), meta_cur};
    end else if (out_load && (op_r == OP_SEARCH)) begin
      meta_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= qend;
    end
    ent_rdata <= entry_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    meta_rdata <= meta_mem[meta_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == BW'(NUM_BUCKETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r  <= op_t'(operation);
            bkt   <= BMAP[bucket_index];
            qend  <= POS_BITS'(position);
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          len        <= meta_fill;
          cur        <= meta_cur;
          bound      <= BOUND_ONE;
          res_status <= (op_r == OP_APPEND) && !room;
          res_len    <= ent_we ? (meta_fill + CW'(1)) : meta_fill;
          lo         <= meta_fill;
          if (op_r == OP_APPEND) begin
            state <= ST_FINISH;
          end else if (meta_cur >= meta_fill) begin
            state <= ST_FINISH;
          end else if ((meta_fill - meta_cur) > CW'(1)) begin
            state <= ST_GREAD;
          end else begin
            state <= ST_BSETUP;
          end
        end
        ST_GREAD: begin
          state <= ST_GCMP;
        end
        ST_GCMP: begin
          bound <= bound_nx;
          state <= flags.more ? ST_GREAD : ST_BSETUP;
        end
        ST_BSETUP: begin
          lo    <= sum;
          count <= count_nx;
          state <= ST_BREAD;
        end
        ST_BREAD: begin
          if (flags.count_zero) begin
            state <= ST_FINISH;
          end else begin
            mid   <= sum;
            state <= ST_BCMP;
          end
        end
        ST_BCMP: begin
          if (flags.less) begin
            lo <= sum;
          end
          count <= count_nx;
          state <= ST_BREAD;
        end
        ST_FINISH: begin
          if (out_load) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            found_index   <= RES_W'(lo);
            bucket_length <= RES_W'(res_len);
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready again right after accepting an item");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (found_index == bucket_length))
    else $error("dropped append reports an index other than the length");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GREAD) |-> (sum < len))
    else $error("gallop probe beyond the bucket fill count");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (lo <= res_len))
    else $error("result index beyond the bucket length");
`endif

endmodule
